@@ design/iate_pkg.sv @@
// shared constants, codes and types for the indexed array table engine
`timescale 1ns / 1ps
`default_nettype none

package iate_pkg;

   // table geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);

   // field widths
   localparam int CMD_W = 3;
   localparam int POS_W = 4;
   localparam int VAL_W = 32;
   localparam int ST_W  = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

   // table memory access from the sequencer
   typedef struct packed {
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic signed [VAL_W-1:0] wr_data;
      logic [IDX_W-1:0]        rd_addr;
   } mem_req_type;

   // operands of the shared compare unit
   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
   } cmp_req_type;

   // compare unit results
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

   // sequencer status seen at the top level
   typedef struct packed {
      logic             idle;
      logic [LEN_W-1:0] length;
   } seq_stat_type;

endpackage

`default_nettype wire

@@ design/iate_req_if.sv @@
// request channel: command word into the engine
`timescale 1ns / 1ps
`default_nettype none

interface iate_req_if;
   import iate_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

`default_nettype wire

@@ design/iate_rsp_if.sv @@
// response channel: result word out of the engine
`timescale 1ns / 1ps
`default_nettype none

interface iate_rsp_if;
   import iate_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] read_value;
   logic [POS_W-1:0]        found_position;
   logic [ST_W-1:0]         status;
   logic                    last;

   modport source (output valid, output read_value, output found_position, output status,
                   output last, input ready);
   modport sink (input valid, input read_value, input found_position, input status,
                 input last, output ready);
endinterface

`default_nettype wire

@@ design/indexed_array_table_engine_top.sv @@
// One item at a time: the table memory, with one write port and one registered read port, and
// the one compare unit serve a single command until its result word is handed on. A word
// waiting at the output does not block the next item until that item has its own word ready.
// Reset (synchronous): length and handshake state clear; table entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_table_engine_top (
   input  wire logic  clock,
   input  wire logic  reset,
   iate_req_if.sink   req_chan,
   iate_rsp_if.source rsp_chan
);
   import iate_pkg::*;

   mem_req_type             mem_req;
   logic signed [VAL_W-1:0] rd_data;
   cmp_req_type             cmp_req;
   cmp_res_type             cmp_res;
   seq_stat_type            seq_stat;

   // table storage
   iate_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit
   iate_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_res (cmp_res)
   );

   // command sequencer
   iate_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .cmp_req  (cmp_req),
      .cmp_res  (cmp_res),
      .seq_stat (seq_stat)
   );

`ifndef NO_ASSERTIONS
   // length never runs past capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      seq_stat.length <= LEN_W'(DEPTH))
      else $error("table length above capacity");

   // length moves by at most one per item
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && seq_stat.length != $past(seq_stat.length)) |->
      (seq_stat.length == $past(seq_stat.length) + LEN_W'(1) ||
       seq_stat.length == $past(seq_stat.length) - LEN_W'(1)))
      else $error("table length jumped");

   // no table write while waiting for a command
   a_idle_nowr: assert property (@(posedge clock) disable iff (reset)
      seq_stat.idle |-> !mem_req.wr_en)
      else $error("table written while idle");
`endif
endmodule

`default_nettype wire

@@ design/iate_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module iate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

@@ design/iate_cmp.sv @@
// shared signed compare unit used by search and sort
`timescale 1ns / 1ps
`default_nettype none

module iate_cmp (
   input  wire iate_pkg::cmp_req_type cmp_req,
   output iate_pkg::cmp_res_type      cmp_res
);
   import iate_pkg::*;

   // signed greater-than and equality on one operand pair
   always_comb begin
      cmp_res.gt = (cmp_req.a > cmp_req.b);
      cmp_res.eq = (cmp_req.a == cmp_req.b);
   end
endmodule

`default_nettype wire

@@ design/iate_seq.sv @@
// command sequencer: length, table walks and result word register
`timescale 1ns / 1ps
`default_nettype none

module iate_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   iate_req_if.sink                           req_chan,
   iate_rsp_if.source                         rsp_chan,
   output iate_pkg::mem_req_type              mem_req,
   input  wire logic signed [iate_pkg::VAL_W-1:0] rd_data,
   output iate_pkg::cmp_req_type              cmp_req,
   input  wire iate_pkg::cmp_res_type         cmp_res,
   output iate_pkg::seq_stat_type             seq_stat
);
   import iate_pkg::*;

   localparam int SW = 5;
   localparam logic [SW-1:0] S_IDLE     = 5'd0;
   localparam logic [SW-1:0] S_GET_CAP  = 5'd1;
   localparam logic [SW-1:0] S_DEL_RD   = 5'd2;
   localparam logic [SW-1:0] S_DEL_WR   = 5'd3;
   localparam logic [SW-1:0] S_INS_RD   = 5'd4;
   localparam logic [SW-1:0] S_INS_WR   = 5'd5;
   localparam logic [SW-1:0] S_INS_PUT  = 5'd6;
   localparam logic [SW-1:0] S_SRCH_RD  = 5'd7;
   localparam logic [SW-1:0] S_SRCH_CMP = 5'd8;
   localparam logic [SW-1:0] S_SORT_I   = 5'd9;
   localparam logic [SW-1:0] S_SORT_LD  = 5'd10;
   localparam logic [SW-1:0] S_SORT_RD  = 5'd11;
   localparam logic [SW-1:0] S_SORT_CMP = 5'd12;
   localparam logic [SW-1:0] S_SORT_WB  = 5'd13;
   localparam logic [SW-1:0] S_DUMP_RD  = 5'd14;
   localparam logic [SW-1:0] S_DUMP_CAP = 5'd15;
   localparam logic [SW-1:0] S_EMIT     = 5'd16;

   localparam logic [LEN_W-1:0] ONE_L = LEN_W'(1);
   localparam logic [LEN_W-1:0] TWO_L = LEN_W'(2);
   localparam logic [LEN_W-1:0] FULL_L = LEN_W'(DEPTH);

   logic [SW-1:0]           state_ff, state_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        i_ff, i_in;
   logic [LEN_W-1:0]        j_ff, j_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] hold_ff, hold_in;
   // pending result word
   logic signed [VAL_W-1:0] p_rv_ff, p_rv_in;
   logic [POS_W-1:0]        p_fp_ff, p_fp_in;
   logic [ST_W-1:0]         p_st_ff, p_st_in;
   logic                    p_last_ff, p_last_in;
   logic                    p_more_ff, p_more_in;
   // output register
   logic                    ov_ff, ov_in;
   logic signed [VAL_W-1:0] o_rv_ff, o_rv_in;
   logic [POS_W-1:0]        o_fp_ff, o_fp_in;
   logic [ST_W-1:0]         o_st_ff, o_st_in;
   logic                    o_last_ff, o_last_in;

   logic                    accept;
   logic [LEN_W-1:0]        req_pos_l;
   logic [LEN_W-1:0]        pos_l;
   logic [LEN_W-1:0]        i_inc;
   logic [LEN_W-1:0]        i_dec;
   logic [LEN_W-1:0]        j_inc;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_pos_l      = LEN_W'(req_chan.position);
   assign pos_l          = LEN_W'(pos_ff);
   assign i_inc          = i_ff + ONE_L;
   assign i_dec          = i_ff - ONE_L;
   assign j_inc          = j_ff + ONE_L;

   // memory address and write selection
   always_comb begin
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = i_ff[IDX_W-1:0];
      mem_req.wr_data = rd_data;
      case (state_ff)
         S_IDLE:    mem_req.rd_addr = IDX_W'(req_chan.position);
         S_DEL_RD:  mem_req.rd_addr = i_inc[IDX_W-1:0];
         S_INS_RD:  mem_req.rd_addr = i_dec[IDX_W-1:0];
         S_SORT_RD: mem_req.rd_addr = j_ff[IDX_W-1:0];
         default:   mem_req.rd_addr = i_ff[IDX_W-1:0];
      endcase
      case (state_ff)
         S_DEL_WR, S_INS_WR: begin
            mem_req.wr_en = 1'b1;
         end
         S_INS_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff[IDX_W-1:0];
            mem_req.wr_data = val_ff;
         end
         S_SORT_CMP: begin
            mem_req.wr_en   = cmp_res.gt;
            mem_req.wr_addr = j_ff[IDX_W-1:0];
            mem_req.wr_data = hold_ff;
         end
         S_SORT_WB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = hold_ff;
         end
         default: begin
            mem_req.wr_en = 1'b0;
         end
      endcase
   end

   // compare unit operands: held entry for sort, search key otherwise
   always_comb begin
      cmp_req.a = (state_ff == S_SORT_CMP) ? hold_ff : val_ff;
      cmp_req.b = rd_data;
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      hold_in   = hold_ff;
      p_rv_in   = p_rv_ff;
      p_fp_in   = p_fp_ff;
      p_st_in   = p_st_ff;
      p_last_in = p_last_ff;
      p_more_in = p_more_ff;
      ov_in     = ov_ff && !rsp_chan.ready;
      o_rv_in   = o_rv_ff;
      o_fp_in   = o_fp_ff;
      o_st_in   = o_st_ff;
      o_last_in = o_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in    = req_chan.position;
               val_in    = req_chan.value;
               p_rv_in   = '0;
               p_fp_in   = '0;
               p_st_in   = ST_OK;
               p_last_in = 1'b1;
               p_more_in = 1'b0;
               i_in      = '0;
               case (req_chan.cmd)
                  CMD_GET: begin
                     if (len_ff == '0) begin
                        p_st_in  = ST_EMPTY;
                        state_in = S_EMIT;
                     end else if (req_pos_l >= len_ff) begin
                        p_st_in  = ST_RANGE;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_GET_CAP;
                     end
                  end
                  CMD_DELETE: begin
                     if (len_ff == '0) begin
                        p_st_in  = ST_EMPTY;
                        state_in = S_EMIT;
                     end else if (req_pos_l >= len_ff) begin
                        p_st_in  = ST_RANGE;
                        state_in = S_EMIT;
                     end else if (req_pos_l + ONE_L < len_ff) begin
                        i_in     = req_pos_l;
                        state_in = S_DEL_RD;
                     end else begin
                        len_in   = len_ff - ONE_L;
                        state_in = S_EMIT;
                     end
                  end
                  CMD_INSERT: begin
                     if (len_ff >= FULL_L) begin
                        p_st_in  = ST_FULL;
                        state_in = S_EMIT;
                     end else if (req_pos_l > len_ff) begin
                        p_st_in  = ST_RANGE;
                        state_in = S_EMIT;
                     end else begin
                        i_in     = len_ff;
                        state_in = (len_ff > req_pos_l) ? S_INS_RD : S_INS_PUT;
                     end
                  end
                  CMD_SEARCH: begin
                     if (len_ff == '0) begin
                        p_st_in  = ST_NOTFOUND;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  CMD_SORT: begin
                     state_in = (len_ff < TWO_L) ? S_EMIT : S_SORT_I;
                  end
                  CMD_DUMP: begin
                     if (len_ff == '0) begin
                        p_st_in  = ST_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     // unused command: dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_GET_CAP: begin
            p_rv_in  = rd_data;
            state_in = S_EMIT;
         end

         // delete: pull each later entry down by one
         S_DEL_RD: begin
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            i_in = i_inc;
            if (i_inc + ONE_L < len_ff) begin
               state_in = S_DEL_RD;
            end else begin
               len_in   = len_ff - ONE_L;
               state_in = S_EMIT;
            end
         end

         // insert: push entries up from the end, then place the value
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            i_in     = i_dec;
            state_in = (i_dec > pos_l) ? S_INS_RD : S_INS_PUT;
         end
         S_INS_PUT: begin
            len_in   = len_ff + ONE_L;
            state_in = S_EMIT;
         end

         // search: first equal entry
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (cmp_res.eq) begin
               p_fp_in  = POS_W'(i_ff);
               state_in = S_EMIT;
            end else if (i_inc < len_ff) begin
               i_in     = i_inc;
               state_in = S_SRCH_RD;
            end else begin
               p_st_in  = ST_NOTFOUND;
               state_in = S_EMIT;
            end
         end

         // exchange sort: entry i is held in a register over the j pass
         S_SORT_I: begin
            j_in     = i_inc;
            state_in = S_SORT_LD;
         end
         S_SORT_LD: begin
            hold_in  = rd_data;
            state_in = S_SORT_RD;
         end
         S_SORT_RD: begin
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (cmp_res.gt) begin
               hold_in = rd_data;
            end
            j_in     = j_inc;
            state_in = (j_inc < len_ff) ? S_SORT_RD : S_SORT_WB;
         end
         S_SORT_WB: begin
            i_in     = i_inc;
            state_in = (i_inc + ONE_L < len_ff) ? S_SORT_I : S_EMIT;
         end

         // dump: one word per entry
         S_DUMP_RD: begin
            state_in = S_DUMP_CAP;
         end
         S_DUMP_CAP: begin
            p_rv_in   = rd_data;
            p_fp_in   = POS_W'(i_ff);
            p_st_in   = ST_OK;
            p_last_in = (i_inc == len_ff);
            p_more_in = (i_inc != len_ff);
            state_in  = S_EMIT;
         end

         // hand the pending word to the output register once it is free
         S_EMIT: begin
            if (!ov_ff || rsp_chan.ready) begin
               ov_in     = 1'b1;
               o_rv_in   = p_rv_ff;
               o_fp_in   = p_fp_ff;
               o_st_in   = p_st_ff;
               o_last_in = p_last_ff;
               if (p_more_ff) begin
                  i_in     = i_inc;
                  state_in = S_DUMP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         ov_ff    <= ov_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      hold_ff   <= hold_in;
      p_rv_ff   <= p_rv_in;
      p_fp_ff   <= p_fp_in;
      p_st_ff   <= p_st_in;
      p_last_ff <= p_last_in;
      p_more_ff <= p_more_in;
      o_rv_ff   <= o_rv_in;
      o_fp_ff   <= o_fp_in;
      o_st_ff   <= o_st_in;
      o_last_ff <= o_last_in;
   end

   // result channel
   assign rsp_chan.valid          = ov_ff;
   assign rsp_chan.read_value     = o_rv_ff;
   assign rsp_chan.found_position = o_fp_ff;
   assign rsp_chan.status         = o_st_ff;
   assign rsp_chan.last           = o_last_ff;

   assign seq_stat.idle   = (state_ff == S_IDLE);
   assign seq_stat.length = len_ff;
endmodule

`default_nettype wire

@@ tb/sv/tb_indexed_array_table_engine_top.sv @@
// self-checking testbench for the indexed array table engine: directed table plus random commands
`timescale 1ns / 1ps

module tb_indexed_array_table_engine_top;
   import iate_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 600;

   // command codes the engine drops without a result
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // one result word as the engine emits it
   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [POS_W-1:0]        found_position;
      logic [ST_W-1:0]         status;
      logic                    last;
   } result_word_type;

   // one row of the directed stimulus table
   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      bit                      fill_first;
      bit                      pinned;
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] read_value;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   iate_req_if req_chan ();
   iate_rsp_if rsp_chan ();

   indexed_array_table_engine_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the table and the words it still owes
   logic signed [VAL_W-1:0] shadow_entries [DEPTH];
   int                      shadow_len = 0;
   result_word_type         pending_words [$];
   directed_row_type        directed_rows [$];

   int  fault_count   = 0;
   int  words_checked = 0;
   int  items_sent    = 0;
   int  peak_len      = 0;
   int  full_hits     = 0;
   int  dumps_sent    = 0;
   bit  sender_quiet  = 1'b0;

   result_word_type seen_word;
   result_word_type want_word;

   // clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // queue one expected word
   function automatic void queue_word(input logic signed [VAL_W-1:0] rv,
                                      input logic [POS_W-1:0] fp,
                                      input logic [ST_W-1:0] st, input logic lst);
      result_word_type w;
      w.read_value     = rv;
      w.found_position = fp;
      w.status         = st;
      w.last           = lst;
      pending_words.push_back(w);
   endfunction

   // table behavior: update the shadow table and queue the words one command owes
   function automatic void run_table_command(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val);
      int                      i;
      int                      j;
      bit                      hit;
      logic signed [VAL_W-1:0] swap;
      case (cmd)
         CMD_GET: begin
            if (shadow_len == 0)
               queue_word('0, '0, ST_EMPTY, 1'b1);
            else if (pos >= shadow_len)
               queue_word('0, '0, ST_RANGE, 1'b1);
            else
               queue_word(shadow_entries[pos], '0, ST_OK, 1'b1);
         end
         CMD_DELETE: begin
            if (shadow_len == 0)
               queue_word('0, '0, ST_EMPTY, 1'b1);
            else if (pos >= shadow_len)
               queue_word('0, '0, ST_RANGE, 1'b1);
            else begin
               for (i = pos; i + 1 < shadow_len; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_len--;
               queue_word('0, '0, ST_OK, 1'b1);
            end
         end
         CMD_INSERT: begin
            if (shadow_len >= DEPTH) begin
               full_hits++;
               queue_word('0, '0, ST_FULL, 1'b1);
            end else if (pos > shadow_len)
               queue_word('0, '0, ST_RANGE, 1'b1);
            else begin
               for (i = shadow_len; i > pos; i--)
                  shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[pos] = val;
               shadow_len++;
               if (shadow_len > peak_len) peak_len = shadow_len;
               queue_word('0, '0, ST_OK, 1'b1);
            end
         end
         CMD_SEARCH: begin
            hit = 1'b0;
            for (i = 0; i < shadow_len; i++) begin
               if (!hit && shadow_entries[i] == val) begin
                  hit = 1'b1;
                  queue_word('0, POS_W'(i), ST_OK, 1'b1);
               end
            end
            if (!hit) queue_word('0, '0, ST_NOTFOUND, 1'b1);
         end
         CMD_SORT: begin
            // exchange sort: each slot against every later slot, signed
            for (i = 0; i + 1 < shadow_len; i++) begin
               for (j = i + 1; j < shadow_len; j++) begin
                  if (shadow_entries[i] > shadow_entries[j]) begin
                     swap              = shadow_entries[i];
                     shadow_entries[i] = shadow_entries[j];
                     shadow_entries[j] = swap;
                  end
               end
            end
            queue_word('0, '0, ST_OK, 1'b1);
         end
         CMD_DUMP: begin
            dumps_sent++;
            if (shadow_len == 0)
               queue_word('0, '0, ST_EMPTY, 1'b1);
            else
               for (i = 0; i < shadow_len; i++)
                  queue_word(shadow_entries[i], POS_W'(i), ST_OK, i + 1 == shadow_len);
         end
         default: ;  // unused codes: no word, no change
      endcase
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // command mix leans toward growth or shrinkage so the table swings full to empty
   function automatic logic [CMD_W-1:0] pick_command(input bit growing);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
      if (growing) begin
         if (r < 50) return CMD_INSERT;
         if (r < 60) return CMD_DELETE;
      end else begin
         if (r < 48) return CMD_DELETE;
         if (r < 60) return CMD_INSERT;
      end
      if (r < 72) return CMD_GET;
      if (r < 84) return CMD_SEARCH;
      if (r < 90) return CMD_SORT;
      return CMD_DUMP;
   endfunction

   // positions mostly in range, the rest anywhere
   function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
      int top;
      top = (cmd == CMD_INSERT) ? shadow_len : shadow_len - 1;
      if (top >= 0 && top < DEPTH && $urandom_range(0, 99) < 80)
         return POS_W'($urandom_range(0, top));
      return POS_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // values: table hits for search, wide random, small clustered values and extremes
   function automatic logic signed [VAL_W-1:0] pick_value(input bit from_table);
      int r;
      r = $urandom_range(0, 99);
      if (from_table && shadow_len > 0 && r < 55)
         return shadow_entries[$urandom_range(0, shadow_len - 1)];
      if (r < 70) return $urandom();
      if (r < 85) return $urandom_range(0, 8) - 4;
      case ($urandom_range(0, 3))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 32'sh00000000;
         default: return -32'sd1;
      endcase
   endfunction

   // append a directed row
   function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                   input logic signed [VAL_W-1:0] val, input bit fill,
                                   input bit pin, input logic [ST_W-1:0] st,
                                   input logic signed [VAL_W-1:0] rv);
      directed_row_type row;
      row.cmd        = cmd;
      row.position   = pos;
      row.value      = val;
      row.fill_first = fill;
      row.pinned     = pin;
      row.status     = st;
      row.read_value = rv;
      directed_rows.push_back(row);
   endfunction

   // offer one command word and wait until the engine takes it
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
      int gap;
      gap = sender_quiet ? 0 : idle_span();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= cmd;
      req_chan.position <= pos;
      req_chan.value    <= val;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      run_table_command(cmd, pos, val);
      if (cmd <= CMD_DUMP) items_sent++;
   endtask

   // stimulus: reset, directed table, then random commands
   initial begin
      directed_row_type        row;
      int                      r;
      int                      n;
      logic [CMD_W-1:0]        cmd;
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;

      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_GET;
      req_chan.position <= '0;
      req_chan.value    <= '0;
      reset             <= 1'b1;

      // empty table cases
      add_row(CMD_GET,      4'd0,  32'sd0,        1'b0, 1'b1, ST_EMPTY,    32'sd0);
      add_row(CMD_DELETE,   4'd0,  32'sd0,        1'b0, 1'b1, ST_EMPTY,    32'sd0);
      add_row(CMD_SEARCH,   4'd0,  32'sd0,        1'b0, 1'b1, ST_NOTFOUND, 32'sd0);
      add_row(CMD_SORT,     4'd0,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_DUMP,     4'd0,  32'sd0,        1'b0, 1'b1, ST_EMPTY,    32'sd0);
      add_row(CMD_INSERT,   4'd1,  32'sd5,        1'b0, 1'b1, ST_RANGE,    32'sd0);
      // build a short table with the extreme values, appending at the end, then inserting at the front
      add_row(CMD_INSERT,   4'd0,  32'sh7fffffff, 1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_INSERT,   4'd1,  32'sh80000000, 1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_INSERT,   4'd0,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_GET,      4'd0,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_GET,      4'd3,  32'sd0,        1'b0, 1'b1, ST_RANGE,    32'sd0);
      add_row(CMD_DELETE,   4'd15, 32'sd0,        1'b0, 1'b1, ST_RANGE,    32'sd0);
      add_row(CMD_SEARCH,   4'd0,  32'sh80000000, 1'b0, 1'b0, ST_OK,       32'sd0);
      add_row(CMD_SEARCH,   4'd0,  -32'sd1,       1'b0, 1'b1, ST_NOTFOUND, 32'sd0);
      add_row(CMD_SORT,     4'd0,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_DUMP,     4'd0,  32'sd0,        1'b0, 1'b0, ST_OK,       32'sd0);
      // unused codes are dropped
      add_row(CMD_SPARE_LO, 4'd15, 32'sh7fffffff, 1'b0, 1'b0, ST_OK,       32'sd0);
      add_row(CMD_SPARE_HI, 4'd5,  -32'sd1,       1'b0, 1'b0, ST_OK,       32'sd0);
      add_row(CMD_DELETE,   4'd1,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_GET,      4'd1,  32'sd0,        1'b0, 1'b0, ST_OK,       32'sd0);
      // full table cases
      add_row(CMD_INSERT,   4'd15, 32'sd9,        1'b1, 1'b1, ST_FULL,     32'sd0);
      add_row(CMD_SORT,     4'd0,  32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);
      add_row(CMD_DUMP,     4'd0,  32'sd0,        1'b0, 1'b0, ST_OK,       32'sd0);
      add_row(CMD_GET,      4'd15, 32'sd0,        1'b0, 1'b0, ST_OK,       32'sd0);
      add_row(CMD_DELETE,   4'd15, 32'sd0,        1'b0, 1'b1, ST_OK,       32'sd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (r = 0; r < directed_rows.size(); r++) begin
         row = directed_rows[r];
         if (row.fill_first)
            while (shadow_len < DEPTH)
               send_item(CMD_INSERT, POS_W'($urandom_range(0, shadow_len)), $urandom());
         send_item(row.cmd, row.position, row.value);
         if (row.pinned) begin
            void'(pending_words.pop_back());
            queue_word(row.read_value, '0, row.status, 1'b1);
         end
      end

      // random commands, alternating growth and shrink phases
      n = 0;
      while (n < RANDOM_ITEMS) begin
         sender_quiet = (n >= 200 && n < 240);
         cmd = pick_command(((n / 50) % 2) == 0);
         pos = pick_position(cmd);
         val = pick_value(cmd == CMD_SEARCH);
         send_item(cmd, pos, val);
         if (cmd <= CMD_DUMP) n++;
      end
      req_chan.valid <= 1'b0;

      // drain and let the engine settle
      while (pending_words.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("ran %0d commands (%0d dumps), checked %0d result words",
               items_sent, dumps_sent, words_checked);
      $display("table reached length %0d, %0d inserts hit a full table", peak_len, full_hits);
      if (fault_count == 0)
         $display("tb_indexed_array_table_engine_top: clean");
      else
         $display("tb_indexed_array_table_engine_top: errors");
      $finish;
   end

   // result side: random stalls plus one long hold-off to back up the engine
   initial begin
      int span;
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && words_checked >= 40) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         span = idle_span();
         if (span > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         repeat (span) @(posedge clock);
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_word.read_value     = rsp_chan.read_value;
         seen_word.found_position = rsp_chan.found_position;
         seen_word.status         = rsp_chan.status;
         seen_word.last           = rsp_chan.last;
         words_checked++;
         if (pending_words.size() == 0) begin
            fault_count++;
            $display("%0t: word with nothing expected: value %0d pos %0d status %0d last %0b",
                     $time, seen_word.read_value, seen_word.found_position,
                     seen_word.status, seen_word.last);
         end else begin
            want_word = pending_words.pop_front();
            if (seen_word !== want_word) begin
               fault_count++;
               $display("%0t: mismatch expected value %0d pos %0d status %0d last %0b",
                        $time, want_word.read_value, want_word.found_position,
                        want_word.status, want_word.last);
               $display("%0t:          actual   value %0d pos %0d status %0d last %0b",
                        $time, seen_word.read_value, seen_word.found_position,
                        seen_word.status, seen_word.last);
            end
         end
      end
   end

   // run limit
   initial begin
      #15_000_000;
      $display("%0t: run limit reached with %0d words outstanding", $time,
               pending_words.size());
      $display("tb_indexed_array_table_engine_top: errors");
      $finish;
   end

endmodule
